@@ rtl/core/smv_pkg.sv @@
// smv_pkg: shared types and constants for the stack mean/variance block.
// Holds the width constants, the status and command codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package smv_pkg;

  localparam int VALUE_W   = 16;
  localparam int FRAC_BITS = 16;
  localparam int MEAN_W    = 32;
  localparam int VAR_W     = 47;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL_NS,
    S_MUL_SQ,
    S_DIV_LOAD,
    S_DIV_MEAN,
    S_MEAN_FIX,
    S_DIV_VAR,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/stack_mean_variance_top.sv @@
// stack_mean_variance_top: bounded stack with running mean and variance.
// One shared two-bit-per-cycle restoring divider serves both statistics.
// Depends on smv_pkg.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   in       | in_valid / in_stall | command, value
//   out      | out_valid/out_stall | count, mean_q16, variance_q16, status
//
// A request runs through update, the multiply states and the divider load; the
// divider then produces the mean, a fix-up state signs it and loads the variance
// division, and the divider produces the variance. Pop on empty skips all arithmetic.
// in_stall is high from acceptance until the result enters the output
// register; a result waiting on out_stall does not block the next request.
// Reset clears count, totals and handshake state; the stack store is not cleared.
`timescale 1ns / 1ps

module stack_mean_variance_top #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 command,
  input  logic signed [smv_pkg::VALUE_W-1:0]   value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     count,
  output logic signed [smv_pkg::MEAN_W-1:0]    mean_q16,
  output logic [smv_pkg::VAR_W-1:0]            variance_q16,
  output logic [1:0]                           status
);
  import smv_pkg::*;

  localparam int CW          = $clog2(STACK_DEPTH + 1);
  localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SW          = VALUE_W + CW;
  localparam int MW          = SW - 1;
  localparam int QW          = 2 * VALUE_W - 2 + CW;
  localparam int DW          = QW + CW;
  localparam int NW          = 2 * CW;
  localparam int DIVW        = DW + FRAC_BITS;
  localparam int MEAN_STEPS  = (MW + FRAC_BITS + 1) / 2;
  localparam int VAR_STEPS   = DIVW / 2;
  localparam int MEAN_SHIFT  = DIVW - 2 * MEAN_STEPS;
  localparam int SCW         = $clog2(VAR_STEPS);

  state_t state, state_next;

  logic signed [VALUE_W-1:0] mem [STACK_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] sample;
  logic                      cmd_pop;
  logic [CW-1:0]             elem_count;
  logic signed [SW-1:0]      sum;
  logic [QW-1:0]             sumsq;
  status_t                   status_r;

  logic                      sum_neg;
  logic [MW-1:0]             mag;
  logic [DW-1:0]             prod_ns;
  logic [DW-1:0]             prod_sq;
  logic [NW-1:0]             divisor;
  logic [DIVW-1:0]           quo;
  logic [NW-1:0]             rem;
  logic [SCW-1:0]            step_cnt;
  logic signed [MEAN_W-1:0]  mean_r;

  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  logic                      mem_we;
  logic [CW-1:0]             cnt_m1;
  logic [AW-1:0]             mem_addr;
  logic signed [VALUE_W-1:0] operand;
  logic signed [2*VALUE_W-1:0] operand_sq;
  logic [SW-1:0]             sum_abs;
  logic [DW-1:0]             diff;
  logic [MEAN_W-1:0]         q_low;
  logic                      out_load;

  logic [NW:0]               t1, t2, s1, s2, dv;
  logic                      ge1, ge2;
  logic [NW-1:0]             r1, r2;

  assign accept   = in_valid && !in_stall;
  assign is_full  = elem_count >= CW'(STACK_DEPTH);
  assign is_empty = elem_count == '0;
  assign cnt_m1   = elem_count - CW'(1);
  assign mem_we   = accept && (command == CMD_PUSH) && !is_full;
  assign mem_addr = (command == CMD_PUSH) ? elem_count[AW-1:0] : cnt_m1[AW-1:0];

  assign operand    = cmd_pop ? rd_data : sample;
  assign operand_sq = (2*VALUE_W)'(operand) * (2*VALUE_W)'(operand);
  assign sum_abs    = sum[SW-1] ? -sum : sum;
  assign diff       = (prod_ns >= prod_sq) ? prod_ns - prod_sq : '0;
  assign q_low      = quo[MEAN_W-1:0];

  // two restoring division steps per cycle
  assign dv  = {1'b0, divisor};
  assign t1  = {rem, quo[DIVW-1]};
  assign s1  = t1 - dv;
  assign ge1 = t1 >= dv;
  assign r1  = ge1 ? s1[NW-1:0] : t1[NW-1:0];
  assign t2  = {r1, quo[DIVW-2]};
  assign s2  = t2 - dv;
  assign ge2 = t2 >= dv;
  assign r2  = ge2 ? s2[NW-1:0] : t2[NW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= value;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (command == CMD_PUSH) begin
            state_next = is_full ? S_MUL_NS : S_UPDATE;
          end else begin
            state_next = is_empty ? S_DONE : S_UPDATE;
          end
        end
      end
      S_UPDATE:   state_next = is_empty ? S_DONE : S_MUL_NS;
      S_MUL_NS:   state_next = S_MUL_SQ;
      S_MUL_SQ:   state_next = S_DIV_LOAD;
      S_DIV_LOAD: state_next = S_DIV_MEAN;
      S_DIV_MEAN: begin
        if (step_cnt == '0) begin
          state_next = S_MEAN_FIX;
        end
      end
      S_MEAN_FIX: state_next = S_DIV_VAR;
      S_DIV_VAR: begin
        if (step_cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      sum        <= '0;
      sumsq      <= '0;
    end else begin
      if (accept) begin
        if (command == CMD_PUSH && !is_full) begin
          elem_count <= elem_count + CW'(1);
        end else if (command == CMD_POP && !is_empty) begin
          elem_count <= cnt_m1;
        end
      end
      if (state == S_UPDATE) begin
        if (cmd_pop) begin
          sum   <= sum - SW'(operand);
          sumsq <= sumsq - QW'($unsigned(operand_sq));
        end else begin
          sum   <= sum + SW'(operand);
          sumsq <= sumsq + QW'($unsigned(operand_sq));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample  <= value;
      cmd_pop <= command;
      if (command == CMD_PUSH) begin
        status_r <= is_full ? ST_PUSH_FULL : ST_OK;
      end else begin
        status_r <= is_empty ? ST_POP_EMPTY : ST_OK;
      end
    end else if (state == S_UPDATE && is_empty) begin
      status_r <= ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_MUL_NS: begin
        prod_ns <= DW'(elem_count) * DW'(sumsq);
        sum_neg <= sum[SW-1];
        mag     <= sum_abs[MW-1:0];
      end
      S_MUL_SQ: begin
        prod_sq <= DW'(mag) * DW'(mag);
        divisor <= NW'(elem_count);
      end
      S_DIV_LOAD: begin
        quo      <= DIVW'({mag, {FRAC_BITS{1'b0}}}) << MEAN_SHIFT;
        rem      <= '0;
        step_cnt <= SCW'(MEAN_STEPS - 1);
      end
      S_DIV_MEAN, S_DIV_VAR: begin
        quo      <= {quo[DIVW-3:0], ge1, ge2};
        rem      <= r2;
        step_cnt <= step_cnt - SCW'(1);
      end
      S_MEAN_FIX: begin
        mean_r   <= sum_neg ? -(q_low + MEAN_W'(|rem)) : q_low;
        quo      <= {diff, {FRAC_BITS{1'b0}}};
        rem      <= '0;
        divisor  <= NW'(elem_count) * NW'(elem_count);
        step_cnt <= SCW'(VAR_STEPS - 1);
      end
      default: begin
        // hold
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      count  <= elem_count;
      status <= status_r;
      if (is_empty) begin
        mean_q16     <= '0;
        variance_q16 <= '0;
      end else begin
        mean_q16     <= mean_r;
        variance_q16 <= quo[VAR_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/smv_checker.sv @@
// smv_checker: port-level checks for stack_mean_variance_top.
// Bound to the top level below; depends on smv_pkg.
`timescale 1ns / 1ps

module smv_checker #(
  parameter int STACK_DEPTH = 256
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [$clog2(STACK_DEPTH+1)-1:0]     count,
  input logic signed [smv_pkg::MEAN_W-1:0]    mean_q16,
  input logic [smv_pkg::VAR_W-1:0]            variance_q16,
  input logic [1:0]                           status
);
  import smv_pkg::*;

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_empty_zero_stats: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_EMPTY || status == ST_POP_EMPTY))
      |-> (count == '0 && mean_q16 == '0 && variance_q16 == '0))
    else $error("empty result carries nonzero statistics");

  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_OK || status == ST_PUSH_FULL)) |-> count != '0)
    else $error("nonempty status with zero count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(mean_q16) && $stable(variance_q16)))
    else $error("stalled result changed");

endmodule

bind stack_mean_variance_top smv_checker #(.STACK_DEPTH(STACK_DEPTH)) u_smv_checker (.*);
